// ===== rtl/core/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants for the fixed-point ray/triangle intersection
// ----------------------------------------------------------------------------
package rti_pkg;

    // internal datapath widths
    localparam int WD     = 104;  // dot products and their sums
    localparam int WQ     = 136;  // scaled numerator and divider remainder
    localparam int DIST_W = 31;   // quotient bits of the distance
    localparam int NSTAGE = 9 + DIST_W + 2;

    // dot product slots
    localparam int DOT_A = 0;
    localparam int DOT_U = 1;
    localparam int DOT_V = 2;
    localparam int DOT_T = 3;

    // miss reason codes
    localparam logic [2:0] RSN_HIT      = 3'd0;
    localparam logic [2:0] RSN_PARALLEL = 3'd1;
    localparam logic [2:0] RSN_U_OUT    = 3'd2;
    localparam logic [2:0] RSN_V_OUT    = 3'd3;
    localparam logic [2:0] RSN_BEHIND   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X    = 3'd3;
    localparam logic [2:0] CFG_DIR_Y    = 3'd4;
    localparam logic [2:0] CFG_DIR_Z    = 3'd5;
    localparam logic [2:0] CFG_EPSILON  = 3'd6;

    typedef logic signed [32:0]   diff_t;
    typedef logic signed [66:0]   part_t;
    typedef logic signed [WD-1:0] wide_t;
    typedef logic signed [WQ-1:0] quot_t;

    typedef struct packed {
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic signed [31:0] v0_z;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v1_z;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v2_z;
    } rti_in_t;

    typedef struct packed {
        logic               hit;
        logic [2:0]         miss_reason;
        logic [30:0]        distance;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } rti_out_t;

endpackage

// ===== rtl/core/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Pipelined Moller-Trumbore ray/triangle test in signed Q16.16 fixed point
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_addr, cfg_data) writes the ray
//   origin, direction and epsilon; cfg_ready is always high. Write only
//   while no triangle is in flight.
//   s channel takes one triangle (three vertices) per transaction.
//   m channel returns one result per triangle, in order: hit flag, miss
//   reason, distance and intersection point.
// Throughput: one triangle per cycle while the skid register is empty. Pipeline:
//   the 31-stage restoring divider that forms the distance one quotient
//   bit per stage, plus 12 arithmetic and output stages.
// Reset: pipeline and output emptied; origin 0, direction (0, 0, -1.0),
//   epsilon 1.
// Stall: a skid register behind the output register catches one result;
//   the pipeline freezes only once the skid register is full, so input
//   transactions continue while a result waits.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rti_pkg::rti_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rti_pkg::rti_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_addr,
    input  logic [31:0]       cfg_data
);
    import rti_pkg::*;

    // configuration
    logic signed [31:0] org_reg [3];
    logic signed [31:0] dir_reg [3];
    logic [15:0]        eps_reg;

    // pipeline control
    logic              en;
    logic [NSTAGE-1:0] vld_reg;
    logic              m_valid_reg;
    rti_out_t          m_data_reg;
    logic              skid_vld_reg;
    rti_out_t          skid_reg;

    // stage 1: edges
    diff_t e1_s1_next [3], e2_s1_next [3], sv_s1_next [3];
    diff_t e1_s1_reg  [3], e2_s1_reg  [3], sv_s1_reg  [3];
    // stage 2: cross product terms
    logic signed [64:0] hp_next [3][2], hp_reg [3][2];
    logic signed [65:0] qp_next [3][2], qp_reg [3][2];
    diff_t e1_s2_reg [3], e2_s2_reg [3], sv_s2_reg [3];
    // stage 3: cross products
    logic signed [65:0] h_next [3], h_reg [3];
    logic signed [66:0] q_next [3], q_reg [3];
    diff_t e1_s3_reg [3], e2_s3_reg [3], sv_s3_reg [3];
    // stage 4: split partial products
    part_t plo_next [4][3], plo_reg [4][3];
    part_t phi_next [4][3], phi_reg [4][3];
    // stage 5: dot product terms
    wide_t term_next [4][3], term_reg [4][3];
    // stage 6: dot products
    wide_t dot_next [4], dot_reg [4];
    // stage 7: sign normalize, parallel test
    wide_t a7_next, un7_next, vn7_next, tn7_next;
    wide_t a7_reg, un7_reg, vn7_reg, tn7_reg;
    logic  par7_next, par7_reg;
    // stage 8: barycentric tests, epsilon times a
    logic [41:0] ep8_next [4], ep8_reg [4];
    logic [2:0]  rsn8_next, rsn8_reg;
    wide_t       a8_reg, tn8_reg;
    // stage 9: distance tests
    quot_t      epsa9, rem9_next, rem9_reg;
    logic       sat9_next, sat9_reg;
    logic [2:0] rsn9_next, rsn9_reg;
    wide_t      a9_reg;
    // divider stages
    quot_t             dv_rem_reg [DIST_W];
    logic [DIST_W-1:0] dv_quo_reg [DIST_W];
    wide_t             dv_a_reg   [DIST_W];
    logic              dv_sat_reg [DIST_W];
    logic [2:0]        dv_rsn_reg [DIST_W];
    // point multiply and final stage
    logic [30:0]        dist_next, dist_reg;
    logic signed [63:0] prod_next [3], prod_reg [3];
    logic [2:0]         rsn_m_reg;
    logic signed [63:0] psum [3];
    logic signed [31:0] pt [3];
    rti_out_t           fin_next, fin_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= -32'sd65536;
            eps_reg    <= 16'd1;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                CFG_DIR_X:    dir_reg[0] <= cfg_data;
                CFG_DIR_Y:    dir_reg[1] <= cfg_data;
                CFG_DIR_Z:    dir_reg[2] <= cfg_data;
                CFG_EPSILON:  eps_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid register is occupied
    assign en      = ~skid_vld_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
        end
    end

    // stage 1: edge vectors and origin offset
    always_comb begin
        e1_s1_next[0] = diff_t'(s_data.v1_x) - diff_t'(s_data.v0_x);
        e1_s1_next[1] = diff_t'(s_data.v1_y) - diff_t'(s_data.v0_y);
        e1_s1_next[2] = diff_t'(s_data.v1_z) - diff_t'(s_data.v0_z);
        e2_s1_next[0] = diff_t'(s_data.v2_x) - diff_t'(s_data.v0_x);
        e2_s1_next[1] = diff_t'(s_data.v2_y) - diff_t'(s_data.v0_y);
        e2_s1_next[2] = diff_t'(s_data.v2_z) - diff_t'(s_data.v0_z);
        sv_s1_next[0] = diff_t'(org_reg[0]) - diff_t'(s_data.v0_x);
        sv_s1_next[1] = diff_t'(org_reg[1]) - diff_t'(s_data.v0_y);
        sv_s1_next[2] = diff_t'(org_reg[2]) - diff_t'(s_data.v0_z);
    end

    // stage 2: products for h = dir x e2 and q = s x e1
    always_comb begin
        hp_next[0][0] = dir_reg[1] * e2_s1_reg[2];
        hp_next[0][1] = dir_reg[2] * e2_s1_reg[1];
        hp_next[1][0] = dir_reg[2] * e2_s1_reg[0];
        hp_next[1][1] = dir_reg[0] * e2_s1_reg[2];
        hp_next[2][0] = dir_reg[0] * e2_s1_reg[1];
        hp_next[2][1] = dir_reg[1] * e2_s1_reg[0];
        qp_next[0][0] = sv_s1_reg[1] * e1_s1_reg[2];
        qp_next[0][1] = sv_s1_reg[2] * e1_s1_reg[1];
        qp_next[1][0] = sv_s1_reg[2] * e1_s1_reg[0];
        qp_next[1][1] = sv_s1_reg[0] * e1_s1_reg[2];
        qp_next[2][0] = sv_s1_reg[0] * e1_s1_reg[1];
        qp_next[2][1] = sv_s1_reg[1] * e1_s1_reg[0];
    end

    // stage 3: cross product differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            h_next[k] = hp_reg[k][0] - hp_reg[k][1];
            q_next[k] = qp_reg[k][0] - qp_reg[k][1];
        end
    end

    // stage 4: dot product terms as low and high partial products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            plo_next[DOT_A][k] = e1_s3_reg[k] * $signed({1'b0, h_reg[k][32:0]});
            phi_next[DOT_A][k] = e1_s3_reg[k] * $signed(h_reg[k][65:33]);
            plo_next[DOT_U][k] = sv_s3_reg[k] * $signed({1'b0, h_reg[k][32:0]});
            phi_next[DOT_U][k] = sv_s3_reg[k] * $signed(h_reg[k][65:33]);
            plo_next[DOT_V][k] = dir_reg[k] * $signed({1'b0, q_reg[k][32:0]});
            phi_next[DOT_V][k] = dir_reg[k] * $signed(q_reg[k][66:33]);
            plo_next[DOT_T][k] = e2_s3_reg[k] * $signed({1'b0, q_reg[k][32:0]});
            phi_next[DOT_T][k] = e2_s3_reg[k] * $signed(q_reg[k][66:33]);
        end
    end

    // stage 5: recombine partial products
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                term_next[j][k] = (wide_t'(phi_reg[j][k]) <<< 33) + wide_t'(plo_reg[j][k]);
            end
        end
    end

    // stage 6: sum of three terms
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            dot_next[j] = term_reg[j][0] + term_reg[j][1] + term_reg[j][2];
        end
    end

    // stage 7: make a positive, parallel test
    always_comb begin
        if (dot_reg[DOT_A][WD-1]) begin
            a7_next  = -dot_reg[DOT_A];
            un7_next = -dot_reg[DOT_U];
            vn7_next = -dot_reg[DOT_V];
            tn7_next = -dot_reg[DOT_T];
        end else begin
            a7_next  = dot_reg[DOT_A];
            un7_next = dot_reg[DOT_U];
            vn7_next = dot_reg[DOT_V];
            tn7_next = dot_reg[DOT_T];
        end
        par7_next = (a7_next == '0) || (a7_next < wide_t'({eps_reg, 32'b0}));
    end

    // stage 8: u and v range tests, epsilon times a in limbs
    always_comb begin
        if (par7_reg) begin
            rsn8_next = RSN_PARALLEL;
        end else if (un7_reg[WD-1] || (un7_reg > a7_reg)) begin
            rsn8_next = RSN_U_OUT;
        end else if (vn7_reg[WD-1] || ((un7_reg + vn7_reg) > a7_reg)) begin
            rsn8_next = RSN_V_OUT;
        end else begin
            rsn8_next = RSN_HIT;
        end
        for (int i = 0; i < 4; i++) begin
            ep8_next[i] = eps_reg * a7_reg[26*i +: 26];
        end
    end

    // stage 9: too-near test and distance saturation
    always_comb begin
        epsa9 = '0;
        for (int i = 0; i < 4; i++) begin
            epsa9 = epsa9 + (quot_t'({{(WQ-42){1'b0}}, ep8_reg[i]}) <<< (26 * i));
        end
        rem9_next = quot_t'(tn8_reg) <<< 16;
        sat9_next = rem9_next >= (quot_t'(a8_reg) <<< DIST_W);
        if (rsn8_reg != RSN_HIT) begin
            rsn9_next = rsn8_reg;
        end else if (rem9_next <= epsa9) begin
            rsn9_next = RSN_BEHIND;
        end else begin
            rsn9_next = RSN_HIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_s1_reg <= e1_s1_next;
            e2_s1_reg <= e2_s1_next;
            sv_s1_reg <= sv_s1_next;
            hp_reg    <= hp_next;
            qp_reg    <= qp_next;
            e1_s2_reg <= e1_s1_reg;
            e2_s2_reg <= e2_s1_reg;
            sv_s2_reg <= sv_s1_reg;
            h_reg     <= h_next;
            q_reg     <= q_next;
            e1_s3_reg <= e1_s2_reg;
            e2_s3_reg <= e2_s2_reg;
            sv_s3_reg <= sv_s2_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            term_reg  <= term_next;
            dot_reg   <= dot_next;
            a7_reg    <= a7_next;
            un7_reg   <= un7_next;
            vn7_reg   <= vn7_next;
            tn7_reg   <= tn7_next;
            par7_reg  <= par7_next;
            ep8_reg   <= ep8_next;
            rsn8_reg  <= rsn8_next;
            a8_reg    <= a7_reg;
            tn8_reg   <= tn7_reg;
            rem9_reg  <= rem9_next;
            sat9_reg  <= sat9_next;
            rsn9_reg  <= rsn9_next;
            a9_reg    <= a8_reg;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar i = 0; i < DIST_W; i++) begin : g_div
        localparam int B = DIST_W - 1 - i;
        quot_t             rin, sh, rem_next;
        logic [DIST_W-1:0] qin, quo_next;
        wide_t             ain;
        logic              sin;
        logic [2:0]        rsn_in;
        logic              ge;

        if (i == 0) begin : g_first
            assign rin    = rem9_reg;
            assign qin    = '0;
            assign ain    = a9_reg;
            assign sin    = sat9_reg;
            assign rsn_in = rsn9_reg;
        end else begin : g_rest
            assign rin    = dv_rem_reg[i-1];
            assign qin    = dv_quo_reg[i-1];
            assign ain    = dv_a_reg[i-1];
            assign sin    = dv_sat_reg[i-1];
            assign rsn_in = dv_rsn_reg[i-1];
        end

        always_comb begin
            sh       = quot_t'(ain) <<< B;
            ge       = rin >= sh;
            rem_next = ge ? rin - sh : rin;
            quo_next = qin;
            quo_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[i] <= rem_next;
                dv_quo_reg[i] <= quo_next;
                dv_a_reg[i]   <= ain;
                dv_sat_reg[i] <= sin;
                dv_rsn_reg[i] <= rsn_in;
            end
        end
    end

    // distance select and direction times distance
    always_comb begin
        if (dv_rsn_reg[DIST_W-1] != RSN_HIT) begin
            dist_next = '0;
        end else if (dv_sat_reg[DIST_W-1]) begin
            dist_next = '1;
        end else begin
            dist_next = dv_quo_reg[DIST_W-1];
        end
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = dir_reg[k] * $signed({1'b0, dist_next});
        end
    end

    // intersection point with floor scaling and saturation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            psum[k] = 64'(org_reg[k]) + (prod_reg[k] >>> 16);
            if (rsn_m_reg != RSN_HIT) begin
                pt[k] = '0;
            end else if (psum[k] > 64'sh7FFF_FFFF) begin
                pt[k] = 32'sh7FFF_FFFF;
            end else if (psum[k] < -64'sh8000_0000) begin
                pt[k] = -32'sh8000_0000;
            end else begin
                pt[k] = psum[k][31:0];
            end
        end
        fin_next.hit         = (rsn_m_reg == RSN_HIT);
        fin_next.miss_reason = rsn_m_reg;
        fin_next.distance    = dist_reg;
        fin_next.point_x     = pt[0];
        fin_next.point_y     = pt[1];
        fin_next.point_z     = pt[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg  <= dist_next;
            prod_reg  <= prod_next;
            rsn_m_reg <= dv_rsn_reg[DIST_W-1];
            fin_reg   <= fin_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= vld_reg[NSTAGE-1];
            end
        end else if (en && vld_reg[NSTAGE-1]) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_data_reg <= skid_reg;
            end else begin
                m_data_reg <= fin_reg;
            end
        end else if (en) begin
            skid_reg <= fin_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
